>>> sv/dlr_pkg.sv
`default_nettype none

package dlr_pkg;

	localparam int COORD_BITS = 10;
	localparam int FRAC_BITS  = 16;

	localparam int ACC_W  = COORD_BITS + FRAC_BITS + 1;
	localparam int STEP_W = FRAC_BITS + 2;
	localparam int QUO_W  = FRAC_BITS + 1;
	localparam int LEFT_W = COORD_BITS + 1;
	localparam int CNT_W  = $clog2(FRAC_BITS);

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	typedef struct packed {
		logic                  command;
		logic [COORD_BITS-1:0] start_x;
		logic [COORD_BITS-1:0] start_y;
		logic [COORD_BITS-1:0] end_x;
		logic [COORD_BITS-1:0] end_y;
	} dlr_in_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
		logic                  last_pixel;
	} dlr_out_t;

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} dlr_state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic emit;
	} dlr_ctl_t;

	typedef struct packed {
		logic active;
		logic last;
		logic out_blocked;
	} dlr_sts_t;

endpackage

`default_nettype wire

>>> sv/dda_line_rasterizer.sv
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+------------------------------
// input    | cmd_valid | cmd_stall | cmd (dlr_in_t): start or tick
// output   | pix_valid | pix_stall | pix (dlr_out_t): one pixel
//
// A tick beat on an active line loads the output register: one pixel per cycle while pix_stall is low.
// A start beat loads the increment divider, a restoring divider that yields one
// quotient bit per cycle for x and y in parallel.
// Reset is asynchronous, active low; it leaves no line active and no pixel pending.
// cmd_stall is high while dividing and while a pixel waits under pix_stall.
`default_nettype none

module dda_line_rasterizer import dlr_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cmd_valid,
	output logic         cmd_stall,
	input  wire dlr_in_t cmd,
	output logic         pix_valid,
	input  wire logic    pix_stall,
	output dlr_out_t     pix
);

	dlr_ctl_t ctl;
	dlr_sts_t sts;

	dlr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.command   (cmd.command),
		.sts       (sts),
		.ctl       (ctl),
		.cmd_stall (cmd_stall)
	);

	dlr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ctl       (ctl),
		.sts       (sts),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix)
	);

	a_div_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_step |-> cmd_stall)
		else $error("beat accepted during division");

	a_pix_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pix_valid) |-> $past(cmd_valid && !cmd_stall && cmd.command == CMD_TICK))
		else $error("pixel without tick beat");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit && sts.last |=> !sts.active && pix.last_pixel)
		else $error("line still active after last pixel");

	a_no_emit_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> !sts.out_blocked && !ctl.load)
		else $error("emit into full output register");

endmodule

`default_nettype wire

>>> sv/dlr_ctrl.sv
`default_nettype none

module dlr_ctrl import dlr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cmd_valid,
	input  wire logic     command,
	input  wire dlr_sts_t sts,
	output dlr_ctl_t      ctl,
	output logic          cmd_stall
);

	dlr_state_t       state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;
	logic             div_done;

	assign div_done = (cnt_q == CNT_W'(FRAC_BITS - 1));

	always_comb begin
		cmd_stall = (state_q == ST_DIV) || sts.out_blocked;
		accept    = cmd_valid && !cmd_stall;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && command == CMD_START) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				ctl.load = accept && command == CMD_START;
				ctl.emit = accept && command == CMD_TICK && sts.active;
			end
			ST_DIV: begin
				ctl.div_step = 1'b1;
			end
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.load) cnt_q <= '0;
			else if (ctl.div_step) cnt_q <= cnt_q + CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

>>> sv/dlr_datapath.sv
`default_nettype none

module dlr_datapath import dlr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire dlr_in_t  cmd,
	input  wire dlr_ctl_t ctl,
	output dlr_sts_t      sts,
	output logic          pix_valid,
	input  wire logic     pix_stall,
	output dlr_out_t      pix
);

	logic signed [ACC_W-1:0] x_accum_q, y_accum_q;
	logic [QUO_W-1:0]        qx_q, qy_q;
	logic                    neg_x_q, neg_y_q;
	logic [COORD_BITS-1:0]   len_q, rx_q, ry_q;
	logic [LEFT_W-1:0]       pixels_left_q;
	logic                    line_active_q;
	logic                    pix_valid_q;
	dlr_out_t                pix_q;

	logic [COORD_BITS-1:0]   ax, ay, len;
	logic                    nx, ny, zx, zy;
	logic signed [ACC_W-1:0] half, x_base, y_base, x_start, y_start;
	logic signed [STEP_W-1:0] x_step, y_step;
	logic [COORD_BITS:0]     rx2, ry2;
	logic                    bx, by;

	function automatic logic [COORD_BITS-1:0] trunc_coord(input logic signed [ACC_W-1:0] acc);
		logic [ACC_W-1:0]      m;
		logic [COORD_BITS-1:0] t;
		m = acc[ACC_W-1] ? (~acc + ACC_W'(1)) : acc;
		t = m[FRAC_BITS +: COORD_BITS];
		return acc[ACC_W-1] ? (~t + COORD_BITS'(1)) : t;
	endfunction

	always_comb begin
		nx  = cmd.end_x < cmd.start_x;
		ny  = cmd.end_y < cmd.start_y;
		zx  = cmd.end_x == cmd.start_x;
		zy  = cmd.end_y == cmd.start_y;
		ax  = nx ? cmd.start_x - cmd.end_x : cmd.end_x - cmd.start_x;
		ay  = ny ? cmd.start_y - cmd.end_y : cmd.end_y - cmd.start_y;
		len = (ax > ay) ? ax : ay;

		half   = ACC_W'(1) << (FRAC_BITS - 1);
		x_base = {1'b0, cmd.start_x, FRAC_BITS'(0)};
		y_base = {1'b0, cmd.start_y, FRAC_BITS'(0)};
		x_start = zx ? x_base : (nx ? x_base - half : x_base + half);
		y_start = zy ? y_base : (ny ? y_base - half : y_base + half);

		rx2 = {rx_q, 1'b0};
		ry2 = {ry_q, 1'b0};
		bx  = (len_q != '0) && (rx2 >= {1'b0, len_q});
		by  = (len_q != '0) && (ry2 >= {1'b0, len_q});

		x_step = neg_x_q ? -$signed({1'b0, qx_q}) : $signed({1'b0, qx_q});
		y_step = neg_y_q ? -$signed({1'b0, qy_q}) : $signed({1'b0, qy_q});
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			len_q   <= len;
			neg_x_q <= nx;
			neg_y_q <= ny;
			qx_q    <= QUO_W'((len != '0) && (ax == len));
			qy_q    <= QUO_W'((len != '0) && (ay == len));
			rx_q    <= (ax == len) ? '0 : ax;
			ry_q    <= (ay == len) ? '0 : ay;
		end else if (ctl.div_step) begin
			qx_q <= {qx_q[QUO_W-2:0], bx};
			qy_q <= {qy_q[QUO_W-2:0], by};
			rx_q <= bx ? COORD_BITS'(rx2 - {1'b0, len_q}) : rx2[COORD_BITS-1:0];
			ry_q <= by ? COORD_BITS'(ry2 - {1'b0, len_q}) : ry2[COORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_accum_q     <= '0;
			y_accum_q     <= '0;
			pixels_left_q <= '0;
			line_active_q <= 1'b0;
		end else if (ctl.load) begin
			x_accum_q     <= x_start;
			y_accum_q     <= y_start;
			pixels_left_q <= {1'b0, len} + LEFT_W'(1);
			line_active_q <= 1'b1;
		end else if (ctl.emit) begin
			x_accum_q     <= x_accum_q + ACC_W'(x_step);
			y_accum_q     <= y_accum_q + ACC_W'(y_step);
			pixels_left_q <= pixels_left_q - LEFT_W'(1);
			if (pixels_left_q == LEFT_W'(1)) line_active_q <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			pix_valid_q <= 1'b1;
		end else if (!pix_stall) begin
			pix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			pix_q.pixel_x    <= trunc_coord(x_accum_q);
			pix_q.pixel_y    <= trunc_coord(y_accum_q);
			pix_q.last_pixel <= (pixels_left_q == LEFT_W'(1));
		end
	end

	assign pix_valid       = pix_valid_q;
	assign pix             = pix_q;
	assign sts.active      = line_active_q;
	assign sts.last        = (pixels_left_q == LEFT_W'(1));
	assign sts.out_blocked = pix_valid_q && pix_stall;

endmodule

`default_nettype wire
